[rtl/core/pwlc_pkg.sv]
// shared constants, codes and control types of the piecewise linear colormap
package pwlc_pkg;

  // table sizes and number format
  localparam int MAX_COLORS    = 64;
  localparam int FRACTION_BITS = 16;
  localparam int COLOR_AW      = $clog2(MAX_COLORS);
  localparam int LEVEL_AW      = $clog2(MAX_COLORS + 1);
  localparam int DATA_W        = 32;
  localparam int CHAN_W        = 8;
  localparam int RGB_W         = 3 * CHAN_W;
  localparam int FUNC_W        = 2;
  localparam int INDEX_W       = 7;
  localparam int COUNT_W       = 7;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 7;
  localparam int CNT_W         = $clog2(FRACTION_BITS);
  localparam int CHAN_LAST     = 2;
  localparam int BLEND_W       = FRACTION_BITS + CHAN_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(5);
  localparam logic [BLEND_W-1:0] ROUND_HALF  = BLEND_W'(1) << (FRACTION_BITS - 1);

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_COLOR = 2'd0,
    FN_LEVEL = 2'd1,
    FN_MAP   = 2'd2
  } func_t;

  // result range codes
  typedef enum logic [STATUS_W-1:0] {
    RS_INSIDE = 2'd0,
    RS_BELOW  = 2'd1,
    RS_ABOVE  = 2'd2
  } range_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_idx_t;

  // level read address select
  typedef enum logic [1:0] {
    LA_FIRST = 2'd0,
    LA_LAST  = 2'd1,
    LA_INNER = 2'd2,
    LA_NEXT  = 2'd3
  } lvl_addr_t;

  // color read address select
  typedef enum logic {
    CA_BIN  = 1'b0,
    CA_NEXT = 1'b1
  } col_addr_t;

  // search outcome written into bin and range status; inside also loads the divider
  typedef enum logic [1:0] {
    OC_NONE   = 2'd0,
    OC_BELOW  = 2'd1,
    OC_ABOVE  = 2'd2,
    OC_INSIDE = 2'd3
  } outcome_t;

  // step counter operation
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_DIV  = 2'd1,
    CNT_CHAN = 2'd2,
    CNT_DEC  = 2'd3
  } cnt_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic      start;
    logic      color_wr;
    logic      level_wr;
    lvl_addr_t lvl_addr;
    logic      keep_prev;
    logic      idx_init;
    logic      idx_inc;
    outcome_t  outcome;
    col_addr_t col_addr;
    logic      res_load;
    logic      chi_load;
    cnt_op_t   cnt_op;
    logic      div_step;
    logic      blend_step;
    logic      out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic x_le;
    logic x_ge;
    logic n_one;
    logic idx_last;
    logic do_blend;
    logic cnt_zero;
  } sts_t;

endpackage

[rtl/core/pwlc_if.sv]
// request and result channel interfaces of the piecewise linear colormap
interface pwlc_in_if;
  logic                                valid;
  logic                                ready;
  logic [pwlc_pkg::FUNC_W-1:0]         func;
  logic [pwlc_pkg::INDEX_W-1:0]        entry_index;
  logic [pwlc_pkg::CHAN_W-1:0]         red_in;
  logic [pwlc_pkg::CHAN_W-1:0]         green_in;
  logic [pwlc_pkg::CHAN_W-1:0]         blue_in;
  logic signed [pwlc_pkg::DATA_W-1:0]  level_value;
  logic signed [pwlc_pkg::DATA_W-1:0]  sample_value;

  modport source (
    output valid, func, entry_index, red_in, green_in, blue_in, level_value, sample_value,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, red_in, green_in, blue_in, level_value, sample_value,
    output ready
  );
endinterface

interface pwlc_out_if;
  logic                              valid;
  logic                              ready;
  logic [pwlc_pkg::CHAN_W-1:0]       red_out;
  logic [pwlc_pkg::CHAN_W-1:0]       green_out;
  logic [pwlc_pkg::CHAN_W-1:0]       blue_out;
  logic [pwlc_pkg::COLOR_AW-1:0]     bin_index;
  logic [pwlc_pkg::STATUS_W-1:0]     range_status;

  modport source (
    output valid, red_out, green_out, blue_out, bin_index, range_status,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, bin_index, range_status,
    output ready
  );
endinterface

[rtl/core/piecewise_linear_colormap_top.sv]
// top level of the piecewise linear colormap
//
//  channel  | dir | handshake           | contents
//  ---------+-----+---------------------+---------------------------------------------
//  in_req   | in  | valid / ready       | func, entry_index, rgb, level, sample
//  out_rsp  | out | valid / ready       | rgb, bin_index, range_status (map only)
//  cfg_*    | in  | cfg_we, no stall    | cfg_index 0 interpolate, 1 color count
//
// a table write is done in the same cycle as its request is taken. a map request
// walks the level RAM one level per cycle, then with blending runs the restoring
// divider and the per-channel blend before it loads its result; the next request
// is taken once the controller is back in idle.
// reset is synchronous, active low; the tables are not cleared.
// a finished result waits in the output register while the next request is
// taken; a map request stalls at its end only while that register is full.
module piecewise_linear_colormap_top (
  input  logic                              clk,
  input  logic                              rst_n,
  pwlc_in_if.sink                           in_req,
  pwlc_out_if.source                        out_rsp,
  input  logic                              cfg_we,
  input  logic [pwlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pwlc_pkg::cmd_t cmd;
  pwlc_pkg::sts_t sts;

  // sequencing
  pwlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_func   (in_req.func),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // tables and arithmetic
  pwlc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_entry_index (in_req.entry_index),
    .in_red         (in_req.red_in),
    .in_green       (in_req.green_in),
    .in_blue        (in_req.blue_in),
    .in_level       (in_req.level_value),
    .in_sample      (in_req.sample_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_red        (out_rsp.red_out),
    .out_green      (out_rsp.green_out),
    .out_blue       (out_rsp.blue_out),
    .out_bin        (out_rsp.bin_index),
    .out_status     (out_rsp.range_status)
  );

  // a result clamped below always points at the first color
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.range_status == pwlc_pkg::RS_BELOW)
      |-> (out_rsp.bin_index == '0))
    else $error("clamped-below result with nonzero bin");

  // a map request holds off further requests on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.func == pwlc_pkg::FN_MAP)
      |=> !in_req.ready)
    else $error("request taken while a map is in progress");

  // a delivered result carries a defined range code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.range_status == pwlc_pkg::RS_INSIDE ||
                       out_rsp.range_status == pwlc_pkg::RS_BELOW ||
                       out_rsp.range_status == pwlc_pkg::RS_ABOVE))
    else $error("result with undefined range status");

endmodule

[rtl/core/pwlc_ram.sv]
// generic single write, single registered read RAM
module pwlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/pwlc_ctrl.sv]
// sequencing controller: level search, color fetch, divide, blend, result hand-off
module pwlc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pwlc_pkg::FUNC_W-1:0] in_func,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pwlc_pkg::cmd_t              cmd,
  input  pwlc_pkg::sts_t              sts
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHK0  = 10'b00_0000_0010,
    S_CHKN  = 10'b00_0000_0100,
    S_SCAN  = 10'b00_0000_1000,
    S_COL   = 10'b00_0001_0000,
    S_CLO   = 10'b00_0010_0000,
    S_CHI   = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_BLEND = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.lvl_addr = pwlc_pkg::LA_FIRST;
    cmd.col_addr = pwlc_pkg::CA_BIN;
    cmd.outcome  = pwlc_pkg::OC_NONE;
    cmd.cnt_op   = pwlc_pkg::CNT_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            pwlc_pkg::FN_COLOR: cmd.color_wr = 1'b1;
            pwlc_pkg::FN_LEVEL: cmd.level_wr = 1'b1;
            pwlc_pkg::FN_MAP: begin
              cmd.start = 1'b1;
              state_nxt = S_CHK0;
            end
            default: ;
          endcase
        end
      end
      // first level is on the read port
      S_CHK0: begin
        cmd.lvl_addr  = pwlc_pkg::LA_LAST;
        cmd.keep_prev = 1'b1;
        if (sts.x_le) begin
          cmd.outcome = pwlc_pkg::OC_BELOW;
          state_nxt   = S_COL;
        end else begin
          state_nxt = S_CHKN;
        end
      end
      // last level is on the read port
      S_CHKN: begin
        cmd.lvl_addr = pwlc_pkg::LA_INNER;
        cmd.idx_init = 1'b1;
        if (sts.x_ge || sts.n_one) begin
          cmd.outcome = pwlc_pkg::OC_ABOVE;
          state_nxt   = S_COL;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      // one inner level per cycle, next read already issued
      S_SCAN: begin
        cmd.lvl_addr  = pwlc_pkg::LA_NEXT;
        cmd.keep_prev = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (!sts.x_ge) begin
          cmd.outcome = pwlc_pkg::OC_INSIDE;
          state_nxt   = S_COL;
        end else if (sts.idx_last) begin
          cmd.outcome = pwlc_pkg::OC_ABOVE;
          state_nxt   = S_COL;
        end
      end
      S_COL: begin
        cmd.col_addr = pwlc_pkg::CA_BIN;
        state_nxt    = S_CLO;
      end
      S_CLO: begin
        cmd.col_addr = pwlc_pkg::CA_NEXT;
        cmd.res_load = 1'b1;
        state_nxt    = sts.do_blend ? S_CHI : S_OUT;
      end
      S_CHI: begin
        cmd.chi_load = 1'b1;
        cmd.cnt_op   = pwlc_pkg::CNT_DIV;
        state_nxt    = S_DIV;
      end
      // one quotient bit per cycle
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_zero) begin
          cmd.cnt_op = pwlc_pkg::CNT_CHAN;
          state_nxt  = S_BLEND;
        end else begin
          cmd.cnt_op = pwlc_pkg::CNT_DEC;
        end
      end
      // one color channel per cycle
      S_BLEND: begin
        cmd.blend_step = 1'b1;
        cmd.cnt_op     = pwlc_pkg::CNT_DEC;
        if (sts.cnt_zero) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/pwlc_dpath.sv]
// datapath: config registers, color and level tables, search, divider, blender
module pwlc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pwlc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwlc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [pwlc_pkg::INDEX_W-1:0]       in_entry_index,
  input  logic [pwlc_pkg::CHAN_W-1:0]        in_red,
  input  logic [pwlc_pkg::CHAN_W-1:0]        in_green,
  input  logic [pwlc_pkg::CHAN_W-1:0]        in_blue,
  input  logic signed [pwlc_pkg::DATA_W-1:0] in_level,
  input  logic signed [pwlc_pkg::DATA_W-1:0] in_sample,
  input  pwlc_pkg::cmd_t                     cmd,
  output pwlc_pkg::sts_t                     sts,
  output logic [pwlc_pkg::CHAN_W-1:0]        out_red,
  output logic [pwlc_pkg::CHAN_W-1:0]        out_green,
  output logic [pwlc_pkg::CHAN_W-1:0]        out_blue,
  output logic [pwlc_pkg::COLOR_AW-1:0]      out_bin,
  output logic [pwlc_pkg::STATUS_W-1:0]      out_status
);

  localparam int DW = pwlc_pkg::DATA_W;
  localparam int FB = pwlc_pkg::FRACTION_BITS;
  localparam int CW = pwlc_pkg::CHAN_W;
  localparam int BW = pwlc_pkg::BLEND_W;

  // configuration
  logic                          interp_r;
  logic [pwlc_pkg::COUNT_W-1:0]  count_r;

  // working registers
  logic signed [DW-1:0]              x_r;
  logic [pwlc_pkg::LEVEL_AW-1:0]     n_r;
  logic [pwlc_pkg::LEVEL_AW-1:0]     idx_r;
  logic signed [DW-1:0]              prev_r;
  logic [pwlc_pkg::COLOR_AW-1:0]     bin_r;
  pwlc_pkg::range_t                  status_r;
  logic [pwlc_pkg::RGB_W-1:0]        res_r;
  logic [pwlc_pkg::RGB_W-1:0]        chi_r;
  logic [DW-1:0]                     rem_r;
  logic [DW-1:0]                     den_r;
  logic [FB-1:0]                     quo_r;
  logic [pwlc_pkg::CNT_W-1:0]        cnt_r;

  // result registers
  logic [pwlc_pkg::RGB_W-1:0]        out_rgb_r;
  logic [pwlc_pkg::COLOR_AW-1:0]     out_bin_r;
  logic [pwlc_pkg::STATUS_W-1:0]     out_status_r;

  // table ports
  logic                              lvl_we;
  logic [pwlc_pkg::LEVEL_AW-1:0]     lvl_raddr;
  logic [DW-1:0]                     lvl_rd;
  logic signed [DW-1:0]              lvl_q;
  logic                              col_we;
  logic [pwlc_pkg::COLOR_AW-1:0]     col_raddr;
  logic [pwlc_pkg::RGB_W-1:0]        col_rd;

  // misc combinational
  logic [pwlc_pkg::LEVEL_AW-1:0]     n_clamp;
  logic signed [DW:0]                num_w;
  logic signed [DW:0]                den_w;
  logic [DW:0]                       rem_sh;
  logic                              q_bit;
  logic [1:0]                        ch;
  logic [CW-1:0]                     chan_a;
  logic [CW-1:0]                     chan_b;
  logic signed [CW:0]                diff;
  logic signed [BW-1:0]              prod;
  logic signed [BW-1:0]              sum;
  logic [CW-1:0]                     blended;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_r <= 1'b0;
      count_r  <= pwlc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwlc_pkg::CFG_INTERP: interp_r <= cfg_data[0];
        pwlc_pkg::CFG_COUNT:  count_r  <= cfg_data[pwlc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // color count limited to 1..MAX_COLORS
  always_comb begin
    if (count_r == '0) begin
      n_clamp = pwlc_pkg::LEVEL_AW'(1);
    end else if (int'(count_r) > pwlc_pkg::MAX_COLORS) begin
      n_clamp = pwlc_pkg::LEVEL_AW'(pwlc_pkg::MAX_COLORS);
    end else begin
      n_clamp = pwlc_pkg::LEVEL_AW'(count_r);
    end
  end

  // table write enables with range check
  assign lvl_we = cmd.level_wr && (int'(in_entry_index) <= pwlc_pkg::MAX_COLORS);
  assign col_we = cmd.color_wr && (int'(in_entry_index) < pwlc_pkg::MAX_COLORS);

  // level read address
  always_comb begin
    case (cmd.lvl_addr)
      pwlc_pkg::LA_FIRST: lvl_raddr = '0;
      pwlc_pkg::LA_LAST:  lvl_raddr = n_r;
      pwlc_pkg::LA_INNER: lvl_raddr = pwlc_pkg::LEVEL_AW'(1);
      pwlc_pkg::LA_NEXT:  lvl_raddr = idx_r + 1'b1;
      default:            lvl_raddr = '0;
    endcase
  end

  assign col_raddr = (cmd.col_addr == pwlc_pkg::CA_NEXT) ? bin_r + 1'b1 : bin_r;

  pwlc_ram #(
    .WIDTH (DW),
    .DEPTH (pwlc_pkg::MAX_COLORS + 1)
  ) u_level_ram (
    .clk     (clk),
    .wr_en   (lvl_we),
    .wr_addr (pwlc_pkg::LEVEL_AW'(in_entry_index)),
    .wr_data (in_level),
    .rd_addr (lvl_raddr),
    .rd_data (lvl_rd)
  );

  pwlc_ram #(
    .WIDTH (pwlc_pkg::RGB_W),
    .DEPTH (pwlc_pkg::MAX_COLORS)
  ) u_color_ram (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (pwlc_pkg::COLOR_AW'(in_entry_index)),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_addr (col_raddr),
    .rd_data (col_rd)
  );

  assign lvl_q = $signed(lvl_rd);

  // span from lower level to sample and to upper level
  assign num_w = $signed({x_r[DW-1], x_r}) - $signed({prev_r[DW-1], prev_r});
  assign den_w = $signed({lvl_q[DW-1], lvl_q}) - $signed({prev_r[DW-1], prev_r});

  // restoring divide step
  assign rem_sh = {rem_r, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  // blend one channel: a + (b - a) * k, rounded
  assign ch      = cnt_r[1:0];
  assign chan_a  = res_r[CW*ch +: CW];
  assign chan_b  = chi_r[CW*ch +: CW];
  assign diff    = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
  assign prod    = BW'(diff) * BW'($signed({1'b0, quo_r}));
  assign sum     = prod + $signed({2'b00, chan_a, {FB{1'b0}}})
                 + $signed(pwlc_pkg::ROUND_HALF);
  assign blended = sum[FB +: CW];

  // status to controller
  assign sts.x_le     = (x_r <= lvl_q);
  assign sts.x_ge     = (x_r >= lvl_q);
  assign sts.n_one    = (n_r == pwlc_pkg::LEVEL_AW'(1));
  assign sts.idx_last = (idx_r == n_r - 1'b1);
  assign sts.do_blend = interp_r && (status_r == pwlc_pkg::RS_INSIDE);
  assign sts.cnt_zero = (cnt_r == '0);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= in_sample;
      n_r <= n_clamp;
    end
    if (cmd.keep_prev) begin
      prev_r <= lvl_q;
    end
    if (cmd.idx_init) begin
      idx_r <= pwlc_pkg::LEVEL_AW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    case (cmd.outcome)
      pwlc_pkg::OC_BELOW: begin
        bin_r    <= '0;
        status_r <= pwlc_pkg::RS_BELOW;
      end
      pwlc_pkg::OC_ABOVE: begin
        bin_r    <= pwlc_pkg::COLOR_AW'(n_r - 1'b1);
        status_r <= pwlc_pkg::RS_ABOVE;
      end
      pwlc_pkg::OC_INSIDE: begin
        bin_r    <= pwlc_pkg::COLOR_AW'(idx_r - 1'b1);
        status_r <= pwlc_pkg::RS_INSIDE;
        rem_r    <= num_w[DW-1:0];
        den_r    <= den_w[DW-1:0];
        quo_r    <= '0;
      end
      default: ;
    endcase
    if (cmd.div_step) begin
      rem_r <= q_bit ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
      quo_r <= {quo_r[FB-2:0], q_bit};
    end
    case (cmd.cnt_op)
      pwlc_pkg::CNT_DIV:  cnt_r <= pwlc_pkg::CNT_W'(FB - 1);
      pwlc_pkg::CNT_CHAN: cnt_r <= pwlc_pkg::CNT_W'(pwlc_pkg::CHAN_LAST);
      pwlc_pkg::CNT_DEC:  cnt_r <= cnt_r - 1'b1;
      default: ;
    endcase
    if (cmd.res_load) begin
      res_r <= col_rd;
    end else if (cmd.blend_step) begin
      res_r[CW*ch +: CW] <= blended;
    end
    if (cmd.chi_load) begin
      chi_r <= col_rd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rgb_r    <= res_r;
      out_bin_r    <= bin_r;
      out_status_r <= status_r;
    end
  end

  assign out_red    = out_rgb_r[2*CW +: CW];
  assign out_green  = out_rgb_r[CW +: CW];
  assign out_blue   = out_rgb_r[0 +: CW];
  assign out_bin    = out_bin_r;
  assign out_status = out_status_r;

endmodule
